[hw/rtl/srtf_pkg.sv]
// Shared types and constants for the shortest-remaining-time-first scheduler.
// Used by srtf_ctrl, srtf_dpath and srtf_scheduler; depends on nothing else.

package srtf_pkg;

  localparam int DEF_MAX_JOBS = 16;
  localparam int ID_BITS      = 8;
  localparam int TIME_BITS    = 16;
  localparam int SUM_BITS     = 20;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [SUM_BITS-1:0]  SUM_MAX  = {SUM_BITS{1'b1}};

  localparam int IN_USER_W   = 1;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_USER_W  = 2;
  localparam int OUT_FIELD_W = ID_BITS + 3 * TIME_BITS + 2 * SUM_BITS + 1;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [ID_BITS-1:0]   job_id;
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] burst;
    logic [TIME_BITS-1:0] remaining;
  } slot_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic update;
    logic calc_wait;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

[hw/rtl/srtf_ctrl.sv]
// Controller state machine of the scheduler: sequences load, scan, update and report.
// Depends on srtf_pkg; drives the datapath srtf_dpath through cmd_t.

module srtf_ctrl
  import srtf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    opcode,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_tready = (state == S_IDLE);
  assign out_free  = !out_tvalid || out_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_tvalid) begin
          if (opcode == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        cmd.calc_wait = 1'b1;
        state_next    = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/srtf_dpath.sv]
// Datapath of the scheduler: slot memory, minimum search, timing math and totals.
// Depends on srtf_pkg; commanded by srtf_ctrl.

module srtf_dpath
  import srtf_pkg::*;
#(
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  slot_t mem [MAX_JOBS];

  logic [ID_BITS-1:0]   in_id;
  logic [TIME_BITS-1:0] in_arr;
  logic [TIME_BITS-1:0] in_burst;

  logic [CNT_W-1:0]     jobs_loaded;
  logic [CNT_W-1:0]     jobs_finished;
  logic [TIME_BITS-1:0] now_time;
  logic [SUM_BITS-1:0]  sum_waiting;
  logic [SUM_BITS-1:0]  sum_turnaround;

  logic [IDX_W-1:0]     scan_idx;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 cmp_vld;
  slot_t                rd_data;

  logic                 best_found;
  logic [IDX_W-1:0]     best_idx;
  slot_t                best;

  logic                 res_ran;
  logic [ID_BITS-1:0]   res_id;
  logic                 res_fin;
  logic [TIME_BITS-1:0] res_comp;
  logic [TIME_BITS-1:0] res_tat;
  logic [TIME_BITS-1:0] res_burst;
  logic [TIME_BITS-1:0] res_wait;

  logic                 load_ok;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  slot_t                wr_data;
  logic                 eligible;
  logic                 better;
  logic [TIME_BITS-1:0] now_next;
  logic [TIME_BITS-1:0] rem_dec;
  logic                 fin;
  logic [TIME_BITS-1:0] tat_calc;
  logic [SUM_BITS:0]    sum_w_wide;
  logic [SUM_BITS:0]    sum_t_wide;
  logic [SUM_BITS-1:0]  sum_w_next;
  logic [SUM_BITS-1:0]  sum_t_next;
  logic                 all_fin;

  assign in_id    = in_tdata[7:0];
  assign in_arr   = in_tdata[23:8];
  assign in_burst = in_tdata[39:24];

  assign load_ok = (in_burst != '0) && (jobs_loaded < CNT_W'(MAX_JOBS));
  assign wr_en   = (cmd.load && load_ok) || (cmd.update && best_found);
  assign wr_addr = cmd.load ? jobs_loaded[IDX_W-1:0] : best_idx;

  assign rem_dec = best.remaining - 1'b1;

  always_comb begin
    if (cmd.load) begin
      wr_data = '{job_id: in_id, arrival: in_arr, burst: in_burst, remaining: in_burst};
    end else begin
      wr_data = '{job_id: best.job_id, arrival: best.arrival, burst: best.burst,
                  remaining: rem_dec};
    end
  end

  assign status.scan_last = (scan_idx == IDX_W'(MAX_JOBS - 1));

  // Slots fill from the bottom and are never freed, so slot i is loaded when i < jobs_loaded.
  assign eligible = cmp_vld && (CNT_W'(cmp_idx) < jobs_loaded) &&
                    (rd_data.remaining != '0) && (rd_data.arrival <= now_time);
  assign better   = !best_found || (rd_data.remaining < best.remaining) ||
                    ((rd_data.remaining == best.remaining) &&
                     (rd_data.arrival < best.arrival));

  assign now_next = (now_time == TIME_MAX) ? now_time : now_time + 1'b1;
  assign fin      = best_found && (rem_dec == '0);
  assign tat_calc = now_next - best.arrival;

  assign sum_w_wide = {1'b0, sum_waiting} + (SUM_BITS + 1)'(res_wait);
  assign sum_t_wide = {1'b0, sum_turnaround} + (SUM_BITS + 1)'(res_tat);
  assign sum_w_next = sum_w_wide[SUM_BITS] ? SUM_MAX : sum_w_wide[SUM_BITS-1:0];
  assign sum_t_next = sum_t_wide[SUM_BITS] ? SUM_MAX : sum_t_wide[SUM_BITS-1:0];
  assign all_fin    = (jobs_finished == jobs_loaded);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_step) begin
      rd_data <= mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jobs_loaded    <= '0;
      jobs_finished  <= '0;
      now_time       <= '0;
      sum_waiting    <= '0;
      sum_turnaround <= '0;
      scan_idx       <= '0;
      cmp_vld        <= 1'b0;
      best_found     <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_step;
      if (cmd.load && load_ok) begin
        jobs_loaded <= jobs_loaded + 1'b1;
      end
      if (cmd.scan_start) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
      end else begin
        if (cmd.scan_step && !status.scan_last) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (eligible && better) begin
          best_found <= 1'b1;
        end
      end
      if (cmd.update) begin
        now_time <= now_next;
        if (fin) begin
          jobs_finished <= jobs_finished + 1'b1;
        end
      end
      if (cmd.commit) begin
        sum_waiting    <= sum_w_next;
        sum_turnaround <= sum_t_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      cmp_idx <= scan_idx;
    end
    if (eligible && better) begin
      best_idx <= cmp_idx;
      best     <= rd_data;
    end
    if (cmd.update) begin
      res_ran   <= best_found;
      res_id    <= best_found ? best.job_id : '0;
      res_fin   <= fin;
      res_comp  <= fin ? now_next : '0;
      res_tat   <= fin ? tat_calc : '0;
      res_burst <= fin ? best.burst : '0;
    end
    if (cmd.calc_wait) begin
      res_wait <= (res_tat > res_burst) ? res_tat - res_burst : '0;
    end
    if (cmd.commit) begin
      out_tuser <= {res_fin, res_ran};
      out_tdata <= {{OUT_PAD_W{1'b0}}, all_fin, sum_t_next, sum_w_next,
                    res_wait, res_tat, res_comp, res_id};
    end
  end

endmodule

[hw/rtl/srtf_scheduler.sv]
// Top level of the shortest-remaining-time-first scheduler.
// Depends on srtf_pkg and instantiates srtf_ctrl and srtf_dpath.

// A load word stores a job in the next free slot of a table of MAX_JOBS slots; it gives no
// result, and it is dropped when the table is full or the burst is zero. A tick word starts
// the search in its accepting cycle; the search reads the slot memory one slot per cycle and
// is followed by the states DRAIN, UPDATE, WAIT and REPORT, which in turn finish the compare,
// update the chosen slot and time, derive the waiting time and register the result. Each tick
// returns one result word, which waits in an output register while the next word is accepted;
// a tick holds in its REPORT state until the previous result is taken.

module srtf_scheduler
  import srtf_pkg::*;
#(
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Bit 0: opcode.
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // From bit 0: job_id, arrival_time, burst_time.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // From bit 0: job_ran, job_finished.
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  // From bit 0: run_id, completion_time, turnaround_time, waiting_time,
  // total_waiting, total_turnaround, all_finished, then zero padding.
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  srtf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (s_axis_tvalid),
    .in_tready  (s_axis_tready),
    .opcode     (s_axis_tuser[0]),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .status     (status),
    .cmd        (cmd)
  );

  srtf_dpath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (s_axis_tdata),
    .out_tuser (m_axis_tuser),
    .out_tdata (m_axis_tdata)
  );

endmodule
